/* design/lcdws_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the character-LCD write sequencer.
// No dependencies; used by every module in the design folder.
package lcdws_pkg;

  localparam int PC_W    = 4;
  localparam int CNT_W   = 5;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int NUM_W   = 32;
  localparam int PAT_W   = 64;

  // request kinds
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CMD    = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_GOTO   = 3'd3;
  localparam logic [2:0] KIND_GLYPH  = 3'd4;
  localparam logic [2:0] KIND_NUMBER = 3'd5;

  // LCD command bytes
  localparam logic [7:0] LCD_FUNC_SET = 8'b0011_1000;
  localparam logic [7:0] LCD_DISP_ON  = 8'b0000_1110;
  localparam logic [7:0] LCD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_DDRAM    = 8'd128;
  localparam logic [7:0] LCD_CGRAM    = 8'd64;
  localparam logic [7:0] LCD_ROW1_OFS = 8'h40;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;

  // counter preloads
  localparam logic [CNT_W-1:0] CNT_PAT_LOAD = CNT_W'(7);
  localparam logic [CNT_W-1:0] CNT_BIN_LOAD = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] CNT_DIG_LOAD = CNT_W'(DIGITS - 1);

  // microcode program entry points
  localparam logic [PC_W-1:0] PC_END   = 4'd0;
  localparam logic [PC_W-1:0] PC_INIT  = 4'd1;
  localparam logic [PC_W-1:0] PC_CMD   = 4'd4;
  localparam logic [PC_W-1:0] PC_DATA  = 4'd5;
  localparam logic [PC_W-1:0] PC_GOTO  = 4'd6;
  localparam logic [PC_W-1:0] PC_GLYPH = 4'd7;
  localparam logic [PC_W-1:0] PC_PAT   = 4'd8;
  localparam logic [PC_W-1:0] PC_NUM   = 4'd11;
  localparam logic [PC_W-1:0] PC_DIGIT = 4'd12;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_RAW,
    SRC_GOTO,
    SRC_CGADDR,
    SRC_PAT,
    SRC_SLOT,
    SRC_DIGIT
  } src_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PAT_SHIFT,
    ACT_DABBLE,
    ACT_DIGIT_SHIFT
  } act_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_LOOP,
    BR_END
  } br_t;

  typedef struct packed {
    logic            emit;
    logic            is_data;
    logic            last;
    src_t            src;
    logic [7:0]      konst;
    act_t            act;
    br_t             br;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic cnt_zero;
    logic skip;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       byte_value;
    logic [5:0]       column;
    logic             row;
    logic [2:0]       glyph_slot;
    logic [PAT_W-1:0] glyph_pattern;
    logic [NUM_W-1:0] number;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } wr_t;

  function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
    logic [PC_W-1:0] pc;
    case (kind)
      KIND_INIT:   pc = PC_INIT;
      KIND_CMD:    pc = PC_CMD;
      KIND_DATA:   pc = PC_DATA;
      KIND_GOTO:   pc = PC_GOTO;
      KIND_GLYPH:  pc = PC_GLYPH;
      KIND_NUMBER: pc = PC_NUM;
      default:     pc = PC_END;
    endcase
    return pc;
  endfunction

endpackage

/* design/lcdws_ucode_rom.sv */
`timescale 1ns / 1ps
// Microcode ROM: one control word per program step.
// Depends on lcdws_pkg.
module lcdws_ucode_rom (
  input  logic [lcdws_pkg::PC_W-1:0] pc,
  output lcdws_pkg::cw_t             cw
);

  always_comb begin
    cw = '{emit: 1'b0, is_data: 1'b0, last: 1'b0, src: lcdws_pkg::SRC_CONST,
           konst: 8'h00, act: lcdws_pkg::ACT_NONE, br: lcdws_pkg::BR_END,
           target: lcdws_pkg::PC_END};
    case (pc)
      lcdws_pkg::PC_INIT: begin
        cw.emit = 1'b1; cw.konst = lcdws_pkg::LCD_FUNC_SET; cw.br = lcdws_pkg::BR_NEXT;
      end
      lcdws_pkg::PC_INIT + 4'd1: begin
        cw.emit = 1'b1; cw.konst = lcdws_pkg::LCD_DISP_ON; cw.br = lcdws_pkg::BR_NEXT;
      end
      lcdws_pkg::PC_INIT + 4'd2: begin
        cw.emit = 1'b1; cw.konst = lcdws_pkg::LCD_CLEAR; cw.last = 1'b1;
      end
      lcdws_pkg::PC_CMD: begin
        cw.emit = 1'b1; cw.src = lcdws_pkg::SRC_RAW; cw.last = 1'b1;
      end
      lcdws_pkg::PC_DATA: begin
        cw.emit = 1'b1; cw.is_data = 1'b1; cw.src = lcdws_pkg::SRC_RAW; cw.last = 1'b1;
      end
      lcdws_pkg::PC_GOTO: begin
        cw.emit = 1'b1; cw.src = lcdws_pkg::SRC_GOTO; cw.last = 1'b1;
      end
      lcdws_pkg::PC_GLYPH: begin
        cw.emit = 1'b1; cw.src = lcdws_pkg::SRC_CGADDR; cw.br = lcdws_pkg::BR_NEXT;
      end
      lcdws_pkg::PC_PAT: begin
        cw.emit = 1'b1; cw.is_data = 1'b1; cw.src = lcdws_pkg::SRC_PAT;
        cw.act = lcdws_pkg::ACT_PAT_SHIFT; cw.br = lcdws_pkg::BR_LOOP;
        cw.target = lcdws_pkg::PC_PAT;
      end
      lcdws_pkg::PC_PAT + 4'd1: begin
        cw.emit = 1'b1; cw.src = lcdws_pkg::SRC_GOTO; cw.br = lcdws_pkg::BR_NEXT;
      end
      lcdws_pkg::PC_PAT + 4'd2: begin
        cw.emit = 1'b1; cw.is_data = 1'b1; cw.src = lcdws_pkg::SRC_SLOT; cw.last = 1'b1;
      end
      lcdws_pkg::PC_NUM: begin
        cw.act = lcdws_pkg::ACT_DABBLE; cw.br = lcdws_pkg::BR_LOOP;
        cw.target = lcdws_pkg::PC_NUM;
      end
      lcdws_pkg::PC_DIGIT: begin
        // last flag of a digit comes from the datapath
        cw.emit = 1'b1; cw.is_data = 1'b1; cw.src = lcdws_pkg::SRC_DIGIT;
        cw.act = lcdws_pkg::ACT_DIGIT_SHIFT; cw.br = lcdws_pkg::BR_LOOP;
        cw.target = lcdws_pkg::PC_DIGIT;
      end
      default: begin
        cw.br = lcdws_pkg::BR_END;
      end
    endcase
  end

endmodule

/* design/lcdws_datapath.sv */
`timescale 1ns / 1ps
// Datapath: request hold registers, pattern shifter, binary-to-BCD unit,
// loop counter and write-byte select. Depends on lcdws_pkg.
module lcdws_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  lcdws_pkg::req_t     req,
  input  logic                step,
  input  lcdws_pkg::cw_t      cw,
  output lcdws_pkg::dp_stat_t stat,
  output lcdws_pkg::wr_t      wr_d
);

  logic [7:0]                      byte_value;
  logic [5:0]                      column;
  logic                            row;
  logic [2:0]                      slot;
  logic [lcdws_pkg::PAT_W-1:0]     pat;
  logic [lcdws_pkg::NUM_W-1:0]     bin;
  logic [lcdws_pkg::BCD_W-1:0]     bcd;
  logic [lcdws_pkg::BCD_W-1:0]     bcd_adj;
  logic [lcdws_pkg::CNT_W-1:0]     cnt;
  logic                            seen;
  logic [3:0]                      digit;
  logic                            digit_last;

  assign digit      = bcd[lcdws_pkg::BCD_W-1 -: 4];
  assign digit_last = (cnt == '0);

  // add-3 correction, one independent nibble per decimal digit
  always_comb begin
    for (int d = 0; d < lcdws_pkg::DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
  end

  always_comb begin
    stat.cnt_zero = (cnt == '0);
    stat.skip     = (cw.src == lcdws_pkg::SRC_DIGIT) && (digit == 4'd0) && !seen && !digit_last;
  end

  always_comb begin
    wr_d.is_data = cw.is_data;
    wr_d.last    = cw.last || ((cw.src == lcdws_pkg::SRC_DIGIT) && digit_last);
    case (cw.src)
      lcdws_pkg::SRC_CONST:  wr_d.bus_byte = cw.konst;
      lcdws_pkg::SRC_RAW:    wr_d.bus_byte = byte_value;
      lcdws_pkg::SRC_GOTO:   wr_d.bus_byte = lcdws_pkg::LCD_DDRAM
                                             + (row ? lcdws_pkg::LCD_ROW1_OFS : 8'h00)
                                             + {2'b00, column};
      lcdws_pkg::SRC_CGADDR: wr_d.bus_byte = lcdws_pkg::LCD_CGRAM + {2'b00, slot, 3'b000};
      lcdws_pkg::SRC_PAT:    wr_d.bus_byte = pat[7:0];
      lcdws_pkg::SRC_SLOT:   wr_d.bus_byte = {5'b00000, slot};
      lcdws_pkg::SRC_DIGIT:  wr_d.bus_byte = lcdws_pkg::ASCII_ZERO + {4'h0, digit};
      default:               wr_d.bus_byte = 8'h00;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      byte_value <= req.byte_value;
      column     <= req.column;
      row        <= req.row;
      slot       <= req.glyph_slot;
      pat        <= req.glyph_pattern;
      bin        <= req.number;
      bcd        <= '0;
    end else if (step) begin
      case (cw.act)
        lcdws_pkg::ACT_PAT_SHIFT:   pat <= pat >> 8;
        lcdws_pkg::ACT_DABBLE:      {bcd, bin} <= {bcd_adj, bin} << 1;
        lcdws_pkg::ACT_DIGIT_SHIFT: bcd <= bcd << 4;
        default: ;
      endcase
    end
  end

  // loop counter and leading-zero flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      seen <= 1'b0;
    end else if (load) begin
      cnt  <= (req.kind == lcdws_pkg::KIND_NUMBER) ? lcdws_pkg::CNT_BIN_LOAD
                                                   : lcdws_pkg::CNT_PAT_LOAD;
      seen <= 1'b0;
    end else if (step && cw.act != lcdws_pkg::ACT_NONE) begin
      cnt <= (cnt == '0) ? lcdws_pkg::CNT_DIG_LOAD : cnt - 1'b1;
      if (cw.act == lcdws_pkg::ACT_DIGIT_SHIFT && digit != 4'd0) begin
        seen <= 1'b1;
      end
    end
  end

endmodule

/* design/char_lcd_write_sequencer.sv */
`timescale 1ns / 1ps
// Character-LCD write sequencer, top level. Depends on lcdws_pkg, lcdws_ucode_rom, lcdws_datapath.
// The first bus write passes through the pc register and then the output register; a number first
//   runs 32 conversion steps and skips leading zeros before its first write.
// Throughput: one request at a time; one microcode step per cycle, plus stalls on wr_ready.
// Reset (rst, synchronous): sequencer idle, output register empty, loop counter and leading-zero flag cleared.
module char_lcd_write_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  lcdws_pkg::req_t req,
  output logic            wr_valid,
  input  logic            wr_ready,
  output lcdws_pkg::wr_t  wr
);

  // sequencer state
  logic                      busy;
  logic [lcdws_pkg::PC_W-1:0] pc;
  lcdws_pkg::cw_t            cw;
  lcdws_pkg::dp_stat_t       stat;
  lcdws_pkg::wr_t            wr_d;

  logic accept;
  logic out_free;
  logic emit_eff;
  logic fire;

  assign req_ready = !busy;
  assign accept    = req_valid && req_ready;

  // the output register is free if empty or being drained this cycle
  assign out_free = !wr_valid || wr_ready;
  // leading-zero digits are skipped without a bus write
  assign emit_eff = cw.emit && !stat.skip;
  // a step retires unless it must write and the output register is full
  assign fire     = busy && (!emit_eff || out_free);

  lcdws_ucode_rom u_rom (
    .pc (pc),
    .cw (cw)
  );

  lcdws_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .req  (req),
    .step (fire),
    .cw   (cw),
    .stat (stat),
    .wr_d (wr_d)
  );

  // step counter with conditional jumps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= lcdws_pkg::PC_END;
    end else if (accept) begin
      busy <= 1'b1;
      pc   <= lcdws_pkg::entry_pc(req.kind);
    end else if (fire) begin
      case (cw.br)
        lcdws_pkg::BR_NEXT: pc <= pc + 1'b1;
        lcdws_pkg::BR_LOOP: pc <= stat.cnt_zero ? pc + 1'b1 : cw.target;
        default: begin
          busy <= 1'b0;
          pc   <= lcdws_pkg::PC_END;
        end
      endcase
    end
  end

  // output register: one bus write transaction held here
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (fire && emit_eff) begin
      wr_valid <= 1'b1;
    end else if (wr_ready) begin
      wr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit_eff) begin
      wr <= wr_d;
    end
  end

  // a pending write that is not the final one means the sequencer still has work
  a_notlast_busy: assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr.last |-> busy)
    else $error("non-final write pending while sequencer idle");

  // the final digit of a number is never suppressed
  a_last_digit_kept: assert property (@(posedge clk) disable iff (rst)
    busy && cw.src == lcdws_pkg::SRC_DIGIT && wr_d.last |-> !stat.skip)
    else $error("final digit skipped");

  // an accepted request always starts the program
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !req_ready)
    else $error("request accepted without starting sequencer");

endmodule

/* tb/sv/char_lcd_write_sequencer_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_write_sequencer: directed and random requests,
// a predicted stream of LCD bus writes, and random idling on both channels.
// Depends on lcdws_pkg and the char_lcd_write_sequencer design.
module char_lcd_write_sequencer_test;

  // Kind codes the block does not decode; they must produce no writes.
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int MAX_WRITES   = 11;
  localparam int MAX_IDLE     = 18;
  localparam int RANDOM_ITEMS = 320;
  localparam int CHUNK_ITEMS  = 40;
  // Longest request is a ten-digit number: conversion plus digits plus pipeline.
  localparam int DRAIN_CYCLES = 80;
  // Slowest legal run is roughly 350 items * (gap + block time + 11 stalled writes);
  // allow several times that.
  localparam int CYCLE_LIMIT  = 500000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic            req_valid = 1'b0;
  logic            req_ready;
  lcdws_pkg::req_t req       = '0;
  logic            wr_valid;
  logic            wr_ready  = 1'b0;
  lcdws_pkg::wr_t  wr;

  char_lcd_write_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr        (wr)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  lcdws_pkg::req_t pending_reqs[$];    // requests waiting for the driver
  lcdws_pkg::wr_t  expected_writes[$]; // bus writes predicted, oldest first
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count    = 0;

  // Idle control: when a "quiet" flag is set that side never idles.
  logic        req_quiet = 1'b0;
  logic        wr_quiet  = 1'b0;
  int unsigned req_gap   = 0;
  int unsigned wr_stall  = 0;

  function automatic int unsigned idle_cycles(input logic quiet);
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // DDRAM address command for a cursor move; wraps modulo 256.
  function automatic logic [7:0] cursor_cmd(input logic [5:0] column, input logic row);
    logic [7:0] addr;
    addr = lcdws_pkg::LCD_DDRAM + {2'b00, column};
    if (row)
      addr = addr + lcdws_pkg::LCD_ROW1_OFS;
    return addr;
  endfunction

  // Expand one request into its bus writes and queue them; the final write
  // of a request carries last.
  task automatic predict_writes(input lcdws_pkg::req_t r);
    logic           sel[MAX_WRITES];
    logic [7:0]     val[MAX_WRITES];
    logic [3:0]     digit[10];
    logic [31:0]    rem;
    int             n;
    int             cnt;
    int             i;
    lcdws_pkg::wr_t w;
    n = 0;
    case (r.kind)
      lcdws_pkg::KIND_INIT: begin
        sel[0] = 1'b0; val[0] = lcdws_pkg::LCD_FUNC_SET;
        sel[1] = 1'b0; val[1] = lcdws_pkg::LCD_DISP_ON;
        sel[2] = 1'b0; val[2] = lcdws_pkg::LCD_CLEAR;
        n = 3;
      end
      lcdws_pkg::KIND_CMD: begin
        sel[0] = 1'b0; val[0] = r.byte_value;
        n = 1;
      end
      lcdws_pkg::KIND_DATA: begin
        sel[0] = 1'b1; val[0] = r.byte_value;
        n = 1;
      end
      lcdws_pkg::KIND_GOTO: begin
        sel[0] = 1'b0; val[0] = cursor_cmd(r.column, r.row);
        n = 1;
      end
      lcdws_pkg::KIND_GLYPH: begin
        sel[0] = 1'b0; val[0] = lcdws_pkg::LCD_CGRAM + {2'b00, r.glyph_slot, 3'b000};
        for (i = 0; i < 8; i++) begin
          sel[i + 1] = 1'b1;
          val[i + 1] = r.glyph_pattern[8 * i +: 8];
        end
        sel[9]  = 1'b0; val[9]  = cursor_cmd(r.column, r.row);
        sel[10] = 1'b1; val[10] = {5'b00000, r.glyph_slot};
        n = 11;
      end
      lcdws_pkg::KIND_NUMBER: begin
        rem = r.number;
        cnt = 0;
        do begin
          digit[cnt] = 4'(rem % 10);
          rem        = rem / 10;
          cnt++;
        end while (rem != 0);
        for (i = cnt - 1; i >= 0; i--) begin
          sel[n] = 1'b1;
          val[n] = lcdws_pkg::ASCII_ZERO + {4'b0000, digit[i]};
          n++;
        end
      end
      default: n = 0;
    endcase
    for (i = 0; i < n; i++) begin
      w.is_data  = sel[i];
      w.bus_byte = val[i];
      w.last     = (i == n - 1);
      expected_writes.push_back(w);
    end
  endtask

  function automatic lcdws_pkg::req_t make_req(input logic [2:0] kind,
                                               input logic [7:0] byte_value,
                                               input logic [5:0] column, input logic row,
                                               input logic [2:0] slot,
                                               input logic [63:0] pattern,
                                               input logic [31:0] number);
    lcdws_pkg::req_t r;
    r.kind          = kind;
    r.byte_value    = byte_value;
    r.column        = column;
    r.row           = row;
    r.glyph_slot    = slot;
    r.glyph_pattern = pattern;
    r.number        = number;
    return r;
  endfunction

  // Random request: mostly decoded kinds, a few spare codes as noise. Unused
  // fields are randomized too so every bit toggles.
  function automatic lcdws_pkg::req_t random_req();
    lcdws_pkg::req_t r;
    int unsigned     sel;
    sel = $urandom_range(0, 99);
    if (sel < 4)
      r.kind = sel[0] ? KIND_SPARE7 : KIND_SPARE6;
    else
      r.kind = 3'($urandom_range(lcdws_pkg::KIND_INIT, lcdws_pkg::KIND_NUMBER));
    r.byte_value    = 8'($urandom);
    // Mostly on-screen columns, sometimes past the display width.
    r.column        = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 39));
    r.row           = 1'($urandom);
    r.glyph_slot    = 3'($urandom);
    r.glyph_pattern = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: r.number = $urandom_range(0, 9);
      1: r.number = $urandom_range(0, 99999);
      2: r.number = $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: r.number = 32'd0;
          1: r.number = 32'd999_999_999;
          2: r.number = 32'd1_000_000_000;
          3: r.number = 32'hFFFF_FFFF;
          4: r.number = 32'd4_000_000_000 + $urandom_range(0, 294_967_295);
          default: r.number = 32'd10 ** $urandom_range(1, 9);
        endcase
      end
    endcase
    return r;
  endfunction

  // Request driver. The slot is free when nothing is offered or the current
  // transaction completes this edge; only then is the next payload loaded, so
  // valid and payload hold steady while the block stalls.
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else if (!req_valid || req_ready) begin
      if (req_valid)
        predict_writes(req);
      if (req_gap != 0) begin
        req_valid <= 1'b0;
        req_gap   <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_gap   <= idle_cycles(req_quiet);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Write monitor. Each accepted write is checked against the oldest
  // prediction, then ready drops for a randomly drawn stall.
  always @(posedge clk) begin : check_writes
    lcdws_pkg::wr_t want;
    int unsigned    hold;
    if (rst) begin
      wr_ready <= 1'b0;
      wr_stall <= 0;
    end else if (wr_valid && wr_ready) begin
      if (expected_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected write: expected none, got is_data=%0d byte=%02h last=%0d",
                 $time, wr.is_data, wr.bus_byte, wr.last);
      end else begin
        want = expected_writes.pop_front();
        if (wr.is_data !== want.is_data || wr.bus_byte !== want.bus_byte ||
            wr.last !== want.last) begin
          mismatch_count++;
          $display("%0t: mismatch, expected %0d/%02h/%0d, got %0d/%02h/%0d",
                   $time, want.is_data, want.bus_byte, want.last,
                   wr.is_data, wr.bus_byte, wr.last);
        end
      end
      hold = idle_cycles(wr_quiet);
      wr_stall <= hold;
      wr_ready <= (hold == 0);
    end else if (wr_stall != 0) begin
      wr_stall <= wr_stall - 1;
      wr_ready <= (wr_stall == 1);
    end else begin
      wr_ready <= 1'b1;
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int              chunk;
    int              issued;
    lcdws_pkg::req_t r;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every kind, spare codes, wide columns,
    // zero and ten-digit numbers.
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_INIT, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_CMD, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_CMD, 8'hFF, 6'd63, 1'b1, 3'd7, '1, '1));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_DATA, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_DATA, 8'hFF, 6'd63, 1'b1, 3'd7, '1, '1));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GOTO, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GOTO, 8'h00, 6'd39, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GOTO, 8'h00, 6'd0, 1'b1, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GOTO, 8'hFF, 6'd63, 1'b1, 3'd7, '1, '1));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GOTO, 8'h00, 6'd40, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GLYPH, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GLYPH, 8'hFF, 6'd63, 1'b1, 3'd7, '1, '1));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_GLYPH, 8'h5A, 6'd39, 1'b1, 3'd5,
                                    64'h0123_4567_89AB_CDEF, 32'd7));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0,
                                    32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0,
                                    32'd9));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0,
                                    32'd10));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0,
                                    32'd999_999_999));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0,
                                    32'd1_000_000_000));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0,
                                    32'd4_000_000_000));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_NUMBER, 8'hFF, 6'd63, 1'b1, 3'd7, '1, '1));
    pending_reqs.push_back(make_req(KIND_SPARE6, 8'hFF, 6'd63, 1'b1, 3'd7, '1, '1));
    pending_reqs.push_back(make_req(KIND_SPARE7, 8'h00, 6'd0, 1'b0, 3'd0, 64'h0, 32'd0));
    pending_reqs.push_back(make_req(lcdws_pkg::KIND_CMD, 8'hA5, 6'd21, 1'b0, 3'd2, 64'h0, 32'd0));

    // Random chunks; idling on each side is switched per chunk so that some
    // stretches run back to back and others see gaps on either channel.
    for (chunk = 0; chunk < RANDOM_ITEMS / CHUNK_ITEMS; chunk++) begin
      while (pending_reqs.size() != 0)
        @(posedge clk);
      req_quiet <= (chunk % 4 == 1) || (chunk % 4 == 3);
      wr_quiet  <= (chunk % 4 == 2) || (chunk % 4 == 3);
      issued = 0;
      while (issued < CHUNK_ITEMS) begin
        r = random_req();
        pending_reqs.push_back(r);
        if (r.kind != KIND_SPARE6 && r.kind != KIND_SPARE7)
          issued++;
      end
    end

    // Drain: all requests accepted, all predicted writes seen, then a pause
    // long enough for any stray write to show up.
    while (pending_reqs.size() != 0 || req_valid)
      @(posedge clk);
    while (expected_writes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lcdws_pkg.sv
design/lcdws_ucode_rom.sv
design/lcdws_datapath.sv
design/char_lcd_write_sequencer.sv
tb/sv/char_lcd_write_sequencer_test.sv
